// File: rtl/core/sps_pkg.sv
package sps_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int DATA_W        = 32;
   localparam int FILL_W        = 5;
   localparam int STATUS_W      = 2;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_POP_EMPTY = 2'd1,
      STAT_PUSH_FULL = 2'd2
   } sps_status_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;       // latch request word, set status, idx = count
      logic rd_scan;      // read entry idx-1
      logic wr_val;       // write new value at idx
      logic wr_shift;     // move read entry up to idx
      logic step_down;    // idx = idx-1
      logic commit_push;  // count+1, maybe new top
      logic pop_commit;   // count-1
      logic rd_top;       // read entry count-1
      logic load_top;     // top = read data
      logic load_rsp;     // fill result register
   } sps_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic op_pop;
      logic err;
      logic idx_zero;
      logic less;
      logic empty;
      logic rsp_free;
   } sps_stat_type;

endpackage

// File: rtl/core/sps_ram.sv
module sps_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/sps_ctrl.sv
module sps_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  sps_pkg::sps_stat_type stat,
   output sps_pkg::sps_cmd_type  cmd
);
   import sps_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_START  = 7'b0000010,
      S_SCAN   = 7'b0000100,
      S_COMP   = 7'b0001000,
      S_POPCHK = 7'b0010000,
      S_POPRD  = 7'b0100000,
      S_DONE   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_START;
            end
         end
         S_START: begin
            if (stat.err) begin
               state_in = S_DONE;
            end else if (stat.op_pop) begin
               cmd.pop_commit = 1'b1;
               state_in       = S_POPCHK;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (stat.idx_zero) begin
               cmd.wr_val      = 1'b1;
               cmd.commit_push = 1'b1;
               state_in        = S_DONE;
            end else begin
               cmd.rd_scan = 1'b1;
               state_in    = S_COMP;
            end
         end
         S_COMP: begin
            // entry below is smaller: lift it and keep going down
            if (stat.less) begin
               cmd.wr_shift  = 1'b1;
               cmd.step_down = 1'b1;
               state_in      = S_SCAN;
            end else begin
               cmd.wr_val      = 1'b1;
               cmd.commit_push = 1'b1;
               state_in        = S_DONE;
            end
         end
         S_POPCHK: begin
            if (stat.empty) begin
               state_in = S_DONE;
            end else begin
               cmd.rd_top = 1'b1;
               state_in   = S_POPRD;
            end
         end
         S_POPRD: begin
            cmd.load_top = 1'b1;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && stat.rsp_free) |=> (state_ff == S_IDLE))
      else $error("result handed off but controller did not return to idle");

   a_one_write: assert property (@(posedge clock) disable iff (reset)
      !(cmd.wr_val && cmd.wr_shift))
      else $error("two RAM write sources in one cycle");

endmodule

// File: rtl/core/sps_dp.sv
module sps_dp #(
   parameter int DEPTH = sps_pkg::DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_op,
   input  logic signed [sps_pkg::DATA_W-1:0]  req_data_value,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output logic signed [sps_pkg::DATA_W-1:0]  rsp_top_value,
   output logic                               rsp_is_empty,
   output logic [sps_pkg::FILL_W-1:0]         rsp_fill_count,
   output logic [sps_pkg::STATUS_W-1:0]       rsp_status,
   input  sps_pkg::sps_cmd_type               cmd,
   output sps_pkg::sps_stat_type              stat
);
   import sps_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   logic                     op_ff, op_in;
   logic signed [DATA_W-1:0] val_ff, val_in;
   logic [CW-1:0]            idx_ff, idx_in;
   logic [CW-1:0]            count_ff, count_in;
   logic signed [DATA_W-1:0] top_ff, top_in;
   sps_status_type           status_ff, status_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_top_ff, rsp_top_in;
   logic                     rsp_empty_ff, rsp_empty_in;
   logic [FILL_W-1:0]        rsp_fill_ff, rsp_fill_in;
   sps_status_type           rsp_status_ff, rsp_status_in;

   logic                     ram_wr_en, ram_rd_en;
   logic [AW-1:0]            ram_wr_addr, ram_rd_addr;
   logic [DATA_W-1:0]        ram_wr_data, ram_rd_data;

   logic                     full, empty;
   logic [CW-1:0]            idx_m1, cnt_m1;
   sps_status_type           acc_status;

   sps_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      full   = (count_ff == FULL_COUNT);
      empty  = (count_ff == '0);
      idx_m1 = idx_ff - 1'b1;
      cnt_m1 = count_ff - 1'b1;

      if (req_op == OP_PUSH && full) begin
         acc_status = STAT_PUSH_FULL;
      end else if (req_op == OP_POP && empty) begin
         acc_status = STAT_POP_EMPTY;
      end else begin
         acc_status = STAT_OK;
      end

      ram_rd_en   = cmd.rd_scan | cmd.rd_top;
      ram_rd_addr = cmd.rd_top ? cnt_m1[AW-1:0] : idx_m1[AW-1:0];
      ram_wr_en   = cmd.wr_val | cmd.wr_shift;
      ram_wr_addr = idx_ff[AW-1:0];
      ram_wr_data = cmd.wr_shift ? ram_rd_data : val_ff;

      stat.op_pop   = (op_ff == OP_POP);
      stat.err      = (status_ff != STAT_OK);
      stat.idx_zero = (idx_ff == '0);
      stat.less     = ($signed(ram_rd_data) < val_ff);
      stat.empty    = empty;
      stat.rsp_free = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      op_in         = op_ff;
      val_in        = val_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      top_in        = top_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_top_in    = rsp_top_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_fill_in   = rsp_fill_ff;
      rsp_status_in = rsp_status_ff;

      if (cmd.accept) begin
         op_in     = req_op;
         val_in    = req_data_value;
         idx_in    = count_ff;
         status_in = acc_status;
      end
      if (cmd.step_down) begin
         idx_in = idx_m1;
      end
      if (cmd.commit_push) begin
         count_in = count_ff + 1'b1;
         // landed in the top slot: new minimum
         if (idx_ff == count_ff) begin
            top_in = val_ff;
         end
      end
      if (cmd.pop_commit) begin
         count_in = cnt_m1;
      end
      if (cmd.load_top) begin
         top_in = ram_rd_data;
      end

      if (cmd.load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_top_in    = empty ? '0 : top_ff;
         rsp_empty_in  = empty;
         rsp_fill_in   = FILL_W'(count_ff);
         rsp_status_in = status_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      val_ff        <= val_in;
      idx_ff        <= idx_in;
      top_ff        <= top_in;
      status_ff     <= status_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_fill_ff   <= rsp_fill_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_top_value  = rsp_top_ff;
   assign rsp_is_empty   = rsp_empty_ff;
   assign rsp_fill_count = rsp_fill_ff;
   assign rsp_status     = rsp_status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count beyond depth");

   a_pop_empty_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STAT_POP_EMPTY) |-> (rsp_empty_ff && rsp_top_ff == '0))
      else $error("pop-on-empty result does not show an empty store");

endmodule

// File: rtl/core/sorted_priority_stack.sv
// channel | dir | handshake             | word
// --------+-----+-----------------------+------------------------------------------------
// req_    | in  | req_valid / req_ready | op, data_value
// rsp_    | out | rsp_valid / rsp_ready | top_value, is_empty, fill_count, status
//
// One word at a time. A full/empty error goes straight to the result; a pop
// refetches the new top from the RAM unless it empties the store; a push reads each
// stored entry smaller than the new value and moves it up one slot (through the
// RAM's separate read and write ports) before writing the new value.
// Reset is synchronous; the store needs no clearing pass. A waiting result sits in
// the output register; the next word is taken meanwhile, its result held until free.
module sorted_priority_stack #(
   parameter int DEPTH = sps_pkg::DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_op,
   input  logic signed [sps_pkg::DATA_W-1:0]  req_data_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [sps_pkg::DATA_W-1:0]  rsp_top_value,
   output logic                               rsp_is_empty,
   output logic [sps_pkg::FILL_W-1:0]         rsp_fill_count,
   output logic [sps_pkg::STATUS_W-1:0]       rsp_status
);
   import sps_pkg::*;

   sps_cmd_type  cmd;
   sps_stat_type stat;

   // sequencer: accept, scan/shift loop for push, top refetch for pop
   sps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // storage (slot 0 = largest), count, cached top and result register
   sps_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_op         (req_op),
      .req_data_value (req_data_value),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_top_value  (rsp_top_value),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_fill_count (rsp_fill_count),
      .rsp_status     (rsp_status),
      .cmd            (cmd),
      .stat           (stat)
   );

endmodule
